FILE: sv/acss_pkg.sv
// Package for the ADC channel scan sequencer: command, action, phase and
// register codes plus the stream payload widths. No dependencies.
`default_nettype none

package acss_pkg;

  // Input item kinds (carried on the slave tuser)
  localparam logic [2:0] CmdScanReq  = 3'd0;
  localparam logic [2:0] CmdMsTick   = 3'd1;
  localparam logic [2:0] CmdWrDone   = 3'd2;
  localparam logic [2:0] CmdRdDone   = 3'd3;
  localparam logic [2:0] CmdBusError = 3'd4;

  // Bus actions requested by a result item (carried on the master tuser)
  localparam logic [2:0] ActNone     = 3'd0;
  localparam logic [2:0] ActWriteCfg = 3'd1;
  localparam logic [2:0] ActRdStatus = 3'd2;
  localparam logic [2:0] ActRdConv   = 3'd3;
  localparam logic [2:0] ActBusReset = 3'd4;

  // Device register pointers
  localparam logic [1:0] PtrConv = 2'd0;
  localparam logic [1:0] PtrCfg  = 2'd1;

  // Sequencer phases
  localparam logic [1:0] PhIdle  = 2'd0;
  localparam logic [1:0] PhStart = 2'd1;
  localparam logic [1:0] PhPoll  = 2'd2;
  localparam logic [1:0] PhRead  = 2'd3;

  // Configuration register indexes (byte address is four times the index)
  localparam logic [2:0] RegChanCount = 3'd0;
  localparam logic [2:0] RegDiffMode  = 3'd1;
  localparam logic [2:0] RegPgaGain   = 3'd2;
  localparam logic [2:0] RegDataRate  = 3'd3;
  localparam logic [2:0] RegTimeout   = 3'd4;

  // Most channels the device offers
  localparam logic [2:0] MaxChannels = 3'd4;

  localparam logic [15:0] TimeoutReset = 16'd4000;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned PaddrW   = 5;

endpackage

`default_nettype wire

FILE: sv/adc_channel_scan_sequencer_unit.sv
// Top level of the ADC channel scan sequencer: stream channels, APB
// configuration registers and the scan state machine. Depends on acss_pkg.
//
// Usage: each input item on the s_axis channel is one bus event: a scan
// request, a millisecond tick, a finished write, a finished read (with the
// word read in rx_data) or a bus error. For every accepted input item the
// block delivers exactly one result item on m_axis, telling the bus master
// what to do next (write the config register, read status, read the
// conversion register, reset the bus, or nothing) and, when a conversion
// has been read, the rescaled sample with its channel. tlast marks the
// sample that ends a scan.
// An accepted input item is held in the input register, which feeds short
// scan-update logic that loads the result register; the result item is
// presented on m_axis from that result register.
// Throughput is one item per cycle while the receiver keeps m_axis_tready high.
// When the receiver stalls, the result register holds its item, the input
// register can still take one more item, and s_axis_tready falls only once
// both registers are occupied.
// Reset (rst_ni low, asynchronous) empties both registers, puts the
// sequencer in idle with channel 0 and a zero millisecond count, and loads
// the configuration registers with their defaults (one channel,
// single-ended, gain and rate codes 0, timeout 4000 ms).
// The user must write configuration through the APB port only while no item
// is in flight (not enforced); writes take effect for the next item processed.
`default_nettype none

module adc_channel_scan_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream: tdata = {pad, bus_busy[16], rx_data[15:0]}, tuser = cmd
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [acss_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic [2:0]                    s_axis_tuser,
  // master stream: tdata = {pad, sample_value[36:21], sample_channel[20:19],
  // sample_valid[18], write_data[17:2], reg_pointer[1:0]}, tuser = action,
  // tlast = scan_done
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [acss_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [2:0]                    m_axis_tuser,
  output logic                          m_axis_tlast,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acss_pkg::PaddrW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import acss_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [2:0]  chan_count_q;
  logic        diff_mode_q;
  logic [2:0]  pga_gain_q;
  logic [2:0]  data_rate_q;
  logic [15:0] timeout_ms_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= 3'd1;
      diff_mode_q  <= 1'b0;
      pga_gain_q   <= 3'd0;
      data_rate_q  <= 3'd0;
      timeout_ms_q <= TimeoutReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegChanCount: chan_count_q <= pwdata[2:0];
        RegDiffMode:  diff_mode_q  <= pwdata[0];
        RegPgaGain:   pga_gain_q   <= pwdata[2:0];
        RegDataRate:  data_rate_q  <= pwdata[2:0];
        RegTimeout:   timeout_ms_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegChanCount: prdata = {29'd0, chan_count_q};
      RegDiffMode:  prdata = {31'd0, diff_mode_q};
      RegPgaGain:   prdata = {29'd0, pga_gain_q};
      RegDataRate:  prdata = {29'd0, data_rate_q};
      RegTimeout:   prdata = {16'd0, timeout_ms_q};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic        in_valid_q;
  logic [2:0]  cmd_q;
  logic [15:0] rx_q;
  logic        busy_q;
  logic        advance;

  // The item in the input register moves on when the result register is
  // empty or its item is being taken this cycle.
  assign advance       = in_valid_q & (~m_axis_tvalid | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= s_axis_tuser;
      rx_q   <= s_axis_tdata[15:0];
      busy_q <= s_axis_tdata[16];
    end
  end

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  // Channel count in use: at least one, at most four, or two for differential pairs.
  logic [2:0] count_hi;
  logic [2:0] eff_count;

  always_comb begin
    count_hi = diff_mode_q ? 3'd2 : 3'd4;
    if (count_hi > MaxChannels) begin
      count_hi = MaxChannels;
    end
    eff_count = chan_count_q;
    if (eff_count < 3'd1) begin
      eff_count = 3'd1;
    end
    if (eff_count > count_hi) begin
      eff_count = count_hi;
    end
  end

  // Config word for a single-shot conversion on channel ch.
  function automatic logic [15:0] cfg_word(input logic [1:0] ch, input logic diff,
                                           input logic [2:0] gain,
                                           input logic [2:0] rate);
    logic [15:0] mux;
    logic [2:0]  g;
    g = (gain > 3'd5) ? 3'd5 : gain;
    if (diff) begin
      unique case (ch)
        2'd0: mux = 16'h0000;
        2'd1: mux = 16'h3000;
        2'd2: mux = 16'h1000;
        2'd3: mux = 16'h2000;
        default: mux = 16'h0000;
      endcase
    end else begin
      mux = 16'h4000 | {2'b00, ch, 12'h000};
    end
    return 16'h8103 | mux | {8'h00, rate, 5'd0} | {4'h0, g, 9'd0};
  endfunction

  // Single-ended samples: negative codes clip to zero, then (x-16383)*2-1,
  // which in 16 bits is 2x + 0x8001.
  logic [15:0] conv_val;
  logic [14:0] se_x;

  always_comb begin
    se_x = rx_q[15] ? 15'd0 : rx_q[14:0];
    conv_val = diff_mode_q ? rx_q : ({se_x, 1'b0} + 16'h8001);
  end

  // ---------------------------------------------------------------------
  // Scan state and result computation
  // ---------------------------------------------------------------------
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  chan_idx_q, chan_idx_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [2:0]  chan_next;

  logic [2:0]  act_d;
  logic [1:0]  ptr_d;
  logic [15:0] wdata_d;
  logic        svalid_d;
  logic [1:0]  sch_d;
  logic [15:0] sval_d;
  logic        done_d;

  assign chan_next = chan_idx_q + 3'd1;

  always_comb begin
    phase_d    = phase_q;
    chan_idx_d = chan_idx_q;
    elapsed_d  = elapsed_q;
    act_d      = ActNone;
    ptr_d      = PtrConv;
    wdata_d    = 16'd0;
    svalid_d   = 1'b0;
    sch_d      = 2'd0;
    sval_d     = 16'd0;
    done_d     = 1'b0;
    unique case (cmd_q)
      CmdScanReq: begin
        // A stale scan (timeout passed) resets the bus instead of starting.
        if (elapsed_q > timeout_ms_q) begin
          act_d      = ActBusReset;
          phase_d    = PhIdle;
          chan_idx_d = 3'd0;
          elapsed_d  = 16'd0;
        end else if (phase_q == PhIdle && !busy_q) begin
          chan_idx_d = 3'd0;
          phase_d    = PhStart;
          act_d      = ActWriteCfg;
          ptr_d      = PtrCfg;
          wdata_d    = cfg_word(2'd0, diff_mode_q, pga_gain_q, data_rate_q);
        end
      end
      CmdMsTick: begin
        if (elapsed_q != 16'hFFFF) begin
          elapsed_d = elapsed_q + 16'd1;
        end
      end
      CmdWrDone: begin
        if (phase_q == PhStart) begin
          phase_d = PhPoll;
          act_d   = ActRdStatus;
          ptr_d   = PtrCfg;
        end
      end
      CmdRdDone: begin
        if (phase_q == PhPoll) begin
          // Bit 15 of the status word means the conversion has finished.
          if (rx_q[15]) begin
            phase_d = PhRead;
            act_d   = ActRdConv;
            ptr_d   = PtrConv;
          end else begin
            act_d = ActRdStatus;
            ptr_d = PtrCfg;
          end
        end else if (phase_q == PhRead) begin
          svalid_d = 1'b1;
          sch_d    = chan_idx_q[1:0];
          sval_d   = conv_val;
          if (chan_next < eff_count) begin
            chan_idx_d = chan_next;
            phase_d    = PhStart;
            act_d      = ActWriteCfg;
            ptr_d      = PtrCfg;
            wdata_d    = cfg_word(chan_next[1:0], diff_mode_q, pga_gain_q, data_rate_q);
          end else begin
            done_d     = 1'b1;
            chan_idx_d = 3'd0;
            elapsed_d  = 16'd0;
            phase_d    = PhIdle;
          end
        end
      end
      CmdBusError: begin
        phase_d = PhIdle;
        act_d   = ActBusReset;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      chan_idx_q <= 3'd0;
      elapsed_q  <= 16'd0;
    end else if (advance) begin
      phase_q    <= phase_d;
      chan_idx_q <= chan_idx_d;
      elapsed_q  <= elapsed_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic        out_valid_q;
  logic [2:0]  act_q;
  logic [1:0]  ptr_q;
  logic [15:0] wdata_q;
  logic        svalid_q;
  logic [1:0]  sch_q;
  logic [15:0] sval_q;
  logic        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      act_q    <= act_d;
      ptr_q    <= ptr_d;
      wdata_q  <= wdata_d;
      svalid_q <= svalid_d;
      sch_q    <= sch_d;
      sval_q   <= sval_d;
      done_q   <= done_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = act_q;
  assign m_axis_tlast  = done_q;
  assign m_axis_tdata  = {3'd0, sval_q, sch_q, svalid_q, wdata_q, ptr_q};

endmodule

`default_nettype wire

FILE: sv/acss_checker.sv
// Port-level checker for the ADC channel scan sequencer and its bind to the
// top level. Depends on acss_pkg and adc_channel_scan_sequencer_unit.
`default_nettype none

module acss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [acss_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [2:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);

  import acss_pkg::*;

  logic        smp_valid;
  logic [1:0]  ptr;
  logic [15:0] wdata;

  assign smp_valid = m_axis_tdata[18];
  assign ptr       = m_axis_tdata[1:0];
  assign wdata     = m_axis_tdata[17:2];

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Scan end only comes with a sample, and then no further bus read.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> smp_valid && m_axis_tuser == ActNone)
    else $error("scan end without a sample");

  // A sample comes from a conversion read and is followed by a write or idle.
  a_smp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && smp_valid |-> m_axis_tuser == ActNone || m_axis_tuser == ActWriteCfg)
    else $error("sample with wrong action");

  // Config register is addressed exactly for config write and status read.
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ptr == PtrCfg) ==
      (m_axis_tuser == ActWriteCfg || m_axis_tuser == ActRdStatus))
    else $error("register pointer does not match action");

  // A config write always starts a single-shot conversion.
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ActWriteCfg |-> wdata[15] && wdata[8] && wdata[1:0] == 2'b11)
    else $error("config word without single-shot bits");

endmodule

bind adc_channel_scan_sequencer_unit acss_checker u_acss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
